// ===== rtl/sit_pkg.sv =====
// Shared types and constants for the sorted insert table.
package sit_pkg;

    localparam int CAPACITY = 32;
    localparam int KEY_W    = 32;
    localparam int PAY_W    = 48;
    localparam int IDX_W    = 5;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_READ   = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_NOP    = 2'd3
    } t_req;

    typedef struct packed {
        logic [1:0]              req_type;
        logic signed [KEY_W-1:0] new_key;
        logic [PAY_W-1:0]        new_payload;
        logic [IDX_W-1:0]        read_index;
    } t_in_item;

    typedef struct packed {
        logic [CNT_W-1:0]        entry_count;
        logic                    table_full;
        logic                    insert_dropped;
        logic                    read_valid;
        logic signed [KEY_W-1:0] read_key;
        logic [PAY_W-1:0]        read_payload;
    } t_out_item;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic                    ins_en;
        logic signed [KEY_W-1:0] key;
        logic [PAY_W-1:0]        payload;
    } t_cell_ctl;

    // Neighbor link: a cell's contents and whether its key exceeds the new key.
    typedef struct packed {
        logic                    gt;
        logic signed [KEY_W-1:0] key;
        logic [PAY_W-1:0]        payload;
    } t_cell_link;

endpackage

// ===== rtl/sit_cell.sv =====
// One table slot: holds an entry, compares against the new key, shifts up on insert.
module sit_cell (
    input  logic                  i_clk,
    input  sit_pkg::t_cell_ctl    i_ctl,
    input  logic                  i_valid,  // slot holds an entry
    input  logic                  i_open,   // first empty slot
    input  sit_pkg::t_cell_link   i_prev,   // lower neighbor
    output sit_pkg::t_cell_link   o_link
);

    logic signed [sit_pkg::KEY_W-1:0] r_key;
    logic [sit_pkg::PAY_W-1:0]        r_payload;
    logic signed [sit_pkg::KEY_W-1:0] n_key;
    logic [sit_pkg::PAY_W-1:0]        n_payload;
    logic                             gt;

    assign gt = i_valid && (r_key > i_ctl.key);

    always_comb begin
        n_key     = r_key;
        n_payload = r_payload;
        if (i_ctl.ins_en && (i_valid || i_open)) begin
            if (i_prev.gt) begin
                // lower neighbor moves up into this slot
                n_key     = i_prev.key;
                n_payload = i_prev.payload;
            end else if (gt || i_open) begin
                n_key     = i_ctl.key;
                n_payload = i_ctl.payload;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_payload <= n_payload;
    end

    assign o_link.gt      = gt;
    assign o_link.key     = r_key;
    assign o_link.payload = r_payload;

endmodule

// ===== rtl/sorted_insert_table_core.sv =====
// Sorted insert table top level: a row of slot cells plus count, read select and result register.
// A result appears with o_result_valid in the cycle after its transaction is accepted.
// Throughput: one transaction per cycle; every slot compares and shifts in the same cycle.
// busy stays low; the receiver cannot stall, each result is shown for exactly one cycle.
// Reset (synchronous, active low) empties the table; slot contents are not cleared and
// are never read until written.
module sorted_insert_table_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  sit_pkg::t_in_item  i_item,
    output logic               o_result_valid,
    output sit_pkg::t_out_item o_result
);

    localparam int N = sit_pkg::CAPACITY;

    logic [sit_pkg::CNT_W-1:0] r_count;
    logic [sit_pkg::CNT_W-1:0] n_count;
    logic                      r_done;
    sit_pkg::t_out_item        r_out;
    sit_pkg::t_out_item        n_out;

    sit_pkg::t_cell_ctl        cell_ctl;
    sit_pkg::t_cell_link       links [N];
    sit_pkg::t_cell_link       link_zero;
    sit_pkg::t_req             req;
    logic                      accept;
    logic                      full;
    logic                      rd_ok;

    // busy is tied low, so the block never holds off a start.
    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign req    = sit_pkg::t_req'(i_item.req_type);
    assign full   = (r_count == sit_pkg::CNT_W'(N));

    // Insert broadcast: key and payload go to every slot at once.
    assign cell_ctl.ins_en  = accept && (req == sit_pkg::REQ_INSERT) && !full;
    assign cell_ctl.key     = i_item.new_key;
    assign cell_ctl.payload = i_item.new_payload;

    assign link_zero = '0;

    // Slot i is valid below the count; the slot at the count is the open one.
    for (genvar gi = 0; gi < N; gi++) begin : g_cell
        sit_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (cell_ctl),
            .i_valid (sit_pkg::CNT_W'(gi) < r_count),
            .i_open  (sit_pkg::CNT_W'(gi) == r_count),
            .i_prev  ((gi == 0) ? link_zero : links[(gi == 0) ? 0 : gi - 1]),
            .o_link  (links[gi])
        );
    end

    assign rd_ok = sit_pkg::CNT_W'(i_item.read_index) < r_count;

    always_comb begin
        n_count = r_count;
        n_out   = '0;
        unique case (req)
            sit_pkg::REQ_INSERT: begin
                if (full) begin
                    n_out.insert_dropped = 1'b1;
                end else begin
                    n_count = r_count + sit_pkg::CNT_W'(1);
                end
            end
            sit_pkg::REQ_READ: begin
                if (rd_ok) begin
                    n_out.read_valid   = 1'b1;
                    n_out.read_key     = links[i_item.read_index].key;
                    n_out.read_payload = links[i_item.read_index].payload;
                end
            end
            sit_pkg::REQ_CLEAR: begin
                n_count = '0;
            end
            sit_pkg::REQ_NOP: begin
                n_count = r_count;
            end
            default: begin
                n_count = r_count;
            end
        endcase
        n_out.entry_count = n_count;
        n_out.table_full  = (n_count == sit_pkg::CNT_W'(N));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= accept;
            if (accept) begin
                r_count <= n_count;
            end
        end
    end

    // Result payload register; only meaningful while the strobe is high.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_result_valid = r_done;
    assign o_result       = r_out;

endmodule

// ===== verif/sit_tb_pkg.sv =====
`timescale 1ns / 1ps
// Scoreboard for the sorted insert table: table prediction and result checking.
package sit_tb_pkg;

    import sit_pkg::*;

    class sit_scoreboard;

        logic signed [KEY_W-1:0] slot_key [CAPACITY];
        logic [PAY_W-1:0]        slot_pay [CAPACITY];
        int                      fill;
        t_out_item               expected_q [$];
        int unsigned             mismatches;

        function new();
            fill       = 0;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(input string msg);
            mismatches++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        // Apply one accepted transaction to the shadow table and queue its status.
        function void note_transaction(input t_in_item it);
            t_out_item r;
            int        pos;
            r = '0;
            case (t_req'(it.req_type))
                REQ_INSERT: begin
                    if (fill >= CAPACITY) begin
                        r.insert_dropped = 1'b1;
                    end else begin
                        // equal keys stay behind older entries
                        pos = fill;
                        while (pos > 0 && $signed(slot_key[pos-1]) > $signed(it.new_key)) begin
                            slot_key[pos] = slot_key[pos-1];
                            slot_pay[pos] = slot_pay[pos-1];
                            pos--;
                        end
                        slot_key[pos] = it.new_key;
                        slot_pay[pos] = it.new_payload;
                        fill++;
                    end
                end
                REQ_READ: begin
                    if (int'(it.read_index) < fill) begin
                        r.read_valid   = 1'b1;
                        r.read_key     = slot_key[it.read_index];
                        r.read_payload = slot_pay[it.read_index];
                    end
                end
                REQ_CLEAR: fill = 0;
                default: ;
            endcase
            r.entry_count = CNT_W'(fill);
            r.table_full  = (fill == CAPACITY);
            expected_q.push_back(r);
        endfunction

        task check_result(input t_out_item got);
            t_out_item want;
            string     diff;
            if (expected_q.size() == 0) begin
                report($sformatf("result with nothing pending: %h", got));
                return;
            end
            want = expected_q.pop_front();
            diff = "";
            if (got.entry_count !== want.entry_count)
                diff = {diff, $sformatf(" entry_count %0d/%0d", got.entry_count,
                                        want.entry_count)};
            if (got.table_full !== want.table_full)
                diff = {diff, $sformatf(" table_full %b/%b", got.table_full, want.table_full)};
            if (got.insert_dropped !== want.insert_dropped)
                diff = {diff, $sformatf(" insert_dropped %b/%b", got.insert_dropped,
                                        want.insert_dropped)};
            if (got.read_valid !== want.read_valid)
                diff = {diff, $sformatf(" read_valid %b/%b", got.read_valid, want.read_valid)};
            if (got.read_key !== want.read_key)
                diff = {diff, $sformatf(" read_key %0d/%0d", got.read_key, want.read_key)};
            if (got.read_payload !== want.read_payload)
                diff = {diff, $sformatf(" read_payload %h/%h", got.read_payload,
                                        want.read_payload)};
            if (diff != "")
                report({"got/expected:", diff});
        endtask

        task report_leftovers();
            if (expected_q.size() != 0)
                report($sformatf("%0d results never arrived", expected_q.size()));
        endtask

    endclass

endpackage

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Top-level testbench for sorted_insert_table_core: directed and random transactions.
module tb_top;

    import sit_pkg::*;
    import sit_tb_pkg::*;

    localparam int ITEM_TARGET = 1550;
    localparam int QUIET_TAIL  = 150;    // last transactions run without gaps

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_item  i_item;
    logic      o_result_valid;
    t_out_item o_result;

    sit_scoreboard sb = new();

    int sent = 0;          // transactions accepted so far
    bit gaps_on = 1'b1;    // sender gaps enabled for the current episode

    sorted_insert_table_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    always #1 i_clk = ~i_clk;

    // Monitor: everything sampled at the rising edge, before the design's updates land.
    // A result is checked before the transaction taken at the same edge is noted;
    // since each result is registered, the two never belong together.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_result_valid !== 1'b0)
                sb.check_result(o_result);
            if (start && busy === 1'b0)
                sb.note_transaction(i_item);
        end
    end

    // Watchdog: far beyond the slowest legal run, with every gap.
    initial begin
        #200000;
        $display("sorted_insert_table_core regression: fail");
        $finish;
    end

    function automatic t_in_item mk(input t_req req, input logic [KEY_W-1:0] key,
                                    input logic [PAY_W-1:0] pay,
                                    input logic [IDX_W-1:0] idx);
        t_in_item it;
        it.req_type    = req;
        it.new_key     = key;
        it.new_payload = pay;
        it.read_index  = idx;
        return it;
    endfunction

    function automatic logic [PAY_W-1:0] rand_pay();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[PAY_W-1:0];
    endfunction

    // mode 0: any key; mode 1: a handful of values around zero, lots of ties;
    // mode 2: mostly the signed extremes, -1 and zero
    function automatic logic [KEY_W-1:0] rand_key(input int mode);
        int v;
        case (mode)
            1: begin
                v = int'($urandom_range(0, 6)) - 3;
                return KEY_W'(v);
            end
            2: begin
                case ($urandom_range(0, 4))
                    0: return {1'b1, {(KEY_W-1){1'b0}}};
                    1: return {1'b0, {(KEY_W-1){1'b1}}};
                    2: return '1;
                    3: return '0;
                    default: return KEY_W'($urandom);
                endcase
            end
            default: return KEY_W'($urandom);
        endcase
    endfunction

    function automatic t_in_item rand_item();
        return mk(t_req'($urandom_range(0, 3)), KEY_W'($urandom), rand_pay(),
                  IDX_W'($urandom));
    endfunction

    // Sender idle for the requested pause; fields keep moving while start is low.
    task automatic pause(input int n);
        start  = 1'b0;
        i_item = rand_item();
        repeat (n) @(negedge i_clk);
    endtask

    // Drive one transaction from a falling edge and hold it until taken.
    task automatic issue(input t_in_item it);
        i_item = it;
        start  = 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        @(negedge i_clk);
        sent++;
        if (gaps_on && sent < ITEM_TARGET - QUIET_TAIL && $urandom_range(0, 4) == 0)
            pause($urandom_range(1, 3));
    endtask

    // Hold off until every pending result has come back.
    task automatic drain();
        start = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    // Optional clear, a run of inserts (sometimes past full) with reads and
    // no-ops mixed in, then a read of every position.
    task automatic fill_episode();
        int mode;
        int target;
        int done;
        mode = $urandom_range(0, 2);
        if ($urandom_range(0, 2) != 0)
            issue(mk(REQ_CLEAR, KEY_W'($urandom), rand_pay(), IDX_W'($urandom)));
        target = $urandom_range(1, CAPACITY + 6);
        done   = 0;
        while (done < target) begin
            if ($urandom_range(0, 4) == 0) begin
                issue(mk($urandom_range(0, 1) ? REQ_READ : REQ_NOP, KEY_W'($urandom),
                         rand_pay(), IDX_W'($urandom)));
            end else begin
                issue(mk(REQ_INSERT, rand_key(mode), rand_pay(), IDX_W'($urandom)));
                done++;
            end
        end
        for (int i = 0; i < CAPACITY; i++)
            issue(mk(REQ_READ, KEY_W'($urandom), rand_pay(), IDX_W'(i)));
    endtask

    initial begin
        int episode;
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_item  = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty table, extreme keys, ties on min/zero/max, out-of-range
        // reads, no-op code, clear and refill.
        issue(mk(REQ_CLEAR, '0, '0, '0));
        issue(mk(REQ_READ,  '0, '0, '0));
        issue(mk(REQ_NOP,   '1, '1, '1));
        issue(mk(REQ_INSERT, '0, 48'h0000_0000_00a1, '0));
        issue(mk(REQ_INSERT, {1'b0, {(KEY_W-1){1'b1}}}, '1, '0));
        issue(mk(REQ_INSERT, {1'b1, {(KEY_W-1){1'b0}}}, '0, '1));
        issue(mk(REQ_INSERT, '1, 48'h5555_5555_5555, '0));
        issue(mk(REQ_INSERT, '0, 48'h0000_0000_00b2, '0));
        issue(mk(REQ_INSERT, {1'b0, {(KEY_W-1){1'b1}}}, 48'haaaa_aaaa_aaaa, '0));
        issue(mk(REQ_INSERT, {1'b1, {(KEY_W-1){1'b0}}}, 48'h8000_0000_0001, '0));
        for (int i = 0; i < 8; i++)
            issue(mk(REQ_READ, '0, '0, IDX_W'(i)));
        issue(mk(REQ_READ,  '0, '0, '1));
        issue(mk(REQ_NOP,   '0, '0, '0));
        issue(mk(REQ_CLEAR, '1, '1, '1));
        issue(mk(REQ_READ,  '0, '0, '0));
        issue(mk(REQ_INSERT, KEY_W'(1), 48'h0000_0000_00c3, '0));
        issue(mk(REQ_READ,  '0, '0, '0));
        drain();

        // Random: mostly fill/read episodes, some pure noise, periodic drains.
        episode = 0;
        while (sent < ITEM_TARGET) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 5) == 0) begin
                repeat ($urandom_range(8, 24)) issue(rand_item());
            end else begin
                fill_episode();
            end
            episode++;
            if (episode % 5 == 0)
                drain();
        end

        // Wind down: let the last results arrive, then keep watching the quiet bus
        // for anything extra.
        start = 1'b0;
        for (int n = 0; n < 1000 && sb.pending() != 0; n++)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        sb.report_leftovers();

        if (sb.mismatches == 0)
            $display("sorted_insert_table_core regression: pass");
        else
            $display("sorted_insert_table_core regression: fail");
        $finish;
    end

endmodule
